// ===== rtl/hdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: shared package
// Widths, fixed-point constants, the CORDIC arctangent table and small
// arithmetic helpers used across the datapath.
// ----------------------------------------------------------------------------
package hdm_pkg;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 35;
  localparam int RAD_W  = 24;

  // Q2.30 angles and CORDIC vectors, with headroom for gain and sign.
  localparam int ANG_W = 34;
  // Magnitude of a reduced angle in half-units, and of a Q30 value up to pi/2.
  localparam int MAG_W = 31;
  localparam int HAV_W = 31;
  localparam int TH_W  = 31;

  localparam int ROT_LANES = 4;
  localparam int LANE_S1   = 0;
  localparam int LANE_S2   = 1;
  localparam int LANE_C1   = 2;
  localparam int LANE_C2   = 3;

  localparam int SQ_LANES  = 2;
  localparam int SQ_STAGES = 31;
  localparam int SQ_W      = 62;

  localparam int PROD_W = RAD_W + 32;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd3600000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd1800000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd900000000;
  localparam logic signed [ANG_W-1:0] GAIN_Q30     = 34'sd652032874;

  // round(pi * 2^62 / 3.6e9): half-units to Q30 radians, scaled by 2^32.
  localparam logic [31:0] RAD_MUL = 32'd4024455254;

  localparam logic [HAV_W-1:0]  HAV_ONE       = 31'h4000_0000;
  localparam logic [TH_W-1:0]   THETA_MAX     = 31'd1686629713;
  localparam logic [RAD_W-1:0]  RADIUS_RESET  = 24'd6371000;
  localparam logic [DIST_W-1:0] DIST_MAX      = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } mid_t;

  typedef struct packed {
    logic [1:0] flip;
    mid_t       mid;
  } rot_tag_t;

  // atan(2^-i) in Q30, rounded from the Q62 series.
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      31:      v = 34'sd1;
      default: begin
        if (i < 31) v = ANG_W'(64'd1 << (30 - i));
        else        v = '0;
      end
    endcase
    return v;
  endfunction

  // Bring an angle difference into [-half turn, half turn].
  function automatic logic signed [ANG_W-1:0] reduce_turn(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] r;
    if (d > HALF_TURN)       r = d - FULL_TURN;
    else if (d < -HALF_TURN) r = d + FULL_TURN;
    else                     r = d;
    return r;
  endfunction

  // Q30 product, rounded half up.
  function automatic logic signed [ANG_W-1:0] mulq(input logic signed [ANG_W-1:0] a,
                                                   input logic signed [ANG_W-1:0] b);
    logic signed [2*ANG_W-1:0] p;
    p = a * b;
    p = p + (2*ANG_W)'(64'd1 << 29);
    return ANG_W'(p >>> 30);
  endfunction

endpackage

// ===== rtl/hdm_if.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: channel interfaces
// Point-pair input, result output and radius write channels.
// ----------------------------------------------------------------------------
interface hdm_in_if import hdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;

  modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                  input ready);
  modport sink   (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                  output ready);
endinterface

interface hdm_out_if import hdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DIST_W-1:0]       distance_mm;
  logic signed [LAT_W-1:0] mid_lat;
  logic signed [LON_W-1:0] mid_lon;

  modport source (output valid, output distance_mm, output mid_lat, output mid_lon,
                  input ready);
  modport sink   (input valid, input distance_mm, input mid_lat, input mid_lon,
                  output ready);
endinterface

interface hdm_cfg_if import hdm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hdm_sincos.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: pipelined CORDIC rotator
// Four independent lanes, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module hdm_sincos import hdm_pkg::*; #(
  parameter int STAGES = 32,
  parameter int TAG_W  = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [TAG_W-1:0]        tag_i,
  input  logic signed [ANG_W-1:0] z_i   [ROT_LANES],
  output logic                    valid_o,
  output logic [TAG_W-1:0]        tag_o,
  output logic signed [ANG_W-1:0] cos_o [ROT_LANES],
  output logic signed [ANG_W-1:0] sin_o [ROT_LANES]
);

  logic signed [ANG_W-1:0] x_d [STAGES][ROT_LANES];
  logic signed [ANG_W-1:0] y_d [STAGES][ROT_LANES];
  logic signed [ANG_W-1:0] z_d [STAGES][ROT_LANES];
  logic signed [ANG_W-1:0] x_q [STAGES][ROT_LANES];
  logic signed [ANG_W-1:0] y_q [STAGES][ROT_LANES];
  logic signed [ANG_W-1:0] z_q [STAGES][ROT_LANES];
  logic [STAGES-1:0]       v_d, v_q;
  logic [TAG_W-1:0]        tag_q [STAGES];

  always_comb begin
    logic signed [ANG_W-1:0] xi, yi, zi;
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < ROT_LANES; l++) begin
        if (s == 0) begin
          xi = GAIN_Q30;
          yi = '0;
          zi = z_i[l];
        end else begin
          xi = x_q[s-1][l];
          yi = y_q[s-1][l];
          zi = z_q[s-1][l];
        end
        if (zi >= 0) begin
          x_d[s][l] = xi - (yi >>> s);
          y_d[s][l] = yi + (xi >>> s);
          z_d[s][l] = zi - atan_q30(s);
        end else begin
          x_d[s][l] = xi + (yi >>> s);
          y_d[s][l] = yi - (xi >>> s);
          z_d[s][l] = zi + atan_q30(s);
        end
      end
    end
  end

  always_comb begin
    v_d[0] = valid_i;
    for (int s = 1; s < STAGES; s++) begin
      v_d[s] = v_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
      tag_q[0] <= tag_i;
      for (int s = 1; s < STAGES; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];
  assign cos_o   = x_q[STAGES-1];
  assign sin_o   = y_q[STAGES-1];

endmodule

// ===== rtl/hdm_isqrt.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: pipelined integer square root
// Two lanes of floor(sqrt(v * 2^30)), one result bit per register stage.
// ----------------------------------------------------------------------------
module hdm_isqrt import hdm_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [TAG_W-1:0]     tag_i,
  input  logic [HAV_W-1:0]     val_i  [SQ_LANES],
  output logic                 valid_o,
  output logic [TAG_W-1:0]     tag_o,
  output logic [HAV_W-1:0]     root_o [SQ_LANES]
);

  logic [SQ_W-1:0]      n_d [SQ_STAGES][SQ_LANES];
  logic [SQ_W-1:0]      r_d [SQ_STAGES][SQ_LANES];
  logic [SQ_W-1:0]      n_q [SQ_STAGES][SQ_LANES];
  logic [SQ_W-1:0]      r_q [SQ_STAGES][SQ_LANES];
  logic [SQ_STAGES-1:0] v_d, v_q;
  logic [TAG_W-1:0]     tag_q [SQ_STAGES];

  always_comb begin
    logic [SQ_W-1:0] ni, ri, bv, trial;
    for (int s = 0; s < SQ_STAGES; s++) begin
      for (int l = 0; l < SQ_LANES; l++) begin
        if (s == 0) begin
          ni = {1'b0, val_i[l], 30'd0};
          ri = '0;
        end else begin
          ni = n_q[s-1][l];
          ri = r_q[s-1][l];
        end
        bv    = SQ_W'(1) << (2 * (SQ_STAGES - 1 - s));
        trial = ri + bv;
        if (ni >= trial) begin
          n_d[s][l] = ni - trial;
          r_d[s][l] = (ri >> 1) + bv;
        end else begin
          n_d[s][l] = ni;
          r_d[s][l] = ri >> 1;
        end
      end
    end
  end

  always_comb begin
    v_d[0] = valid_i;
    for (int s = 1; s < SQ_STAGES; s++) begin
      v_d[s] = v_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q      <= n_d;
      r_q      <= r_d;
      tag_q[0] <= tag_i;
      for (int s = 1; s < SQ_STAGES; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < SQ_LANES; l++) begin
      root_o[l] = r_q[SQ_STAGES-1][l][HAV_W-1:0];
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign tag_o   = tag_q[SQ_STAGES-1];

endmodule

// ===== rtl/hdm_vector.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: pipelined CORDIC vectoring unit
// Drives y to zero and accumulates the angle of (x, y) in Q30.
// ----------------------------------------------------------------------------
module hdm_vector import hdm_pkg::*; #(
  parameter int STAGES = 32,
  parameter int TAG_W  = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [TAG_W-1:0]        tag_i,
  input  logic [HAV_W-1:0]        x_i,
  input  logic [HAV_W-1:0]        y_i,
  output logic                    valid_o,
  output logic [TAG_W-1:0]        tag_o,
  output logic signed [ANG_W-1:0] theta_o
);

  logic signed [ANG_W-1:0] x_d [STAGES];
  logic signed [ANG_W-1:0] y_d [STAGES];
  logic signed [ANG_W-1:0] z_d [STAGES];
  logic signed [ANG_W-1:0] x_q [STAGES];
  logic signed [ANG_W-1:0] y_q [STAGES];
  logic signed [ANG_W-1:0] z_q [STAGES];
  logic [STAGES-1:0]       v_d, v_q;
  logic [TAG_W-1:0]        tag_q [STAGES];

  always_comb begin
    logic signed [ANG_W-1:0] xi, yi, zi;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        xi = $signed({{(ANG_W-HAV_W){1'b0}}, x_i});
        yi = $signed({{(ANG_W-HAV_W){1'b0}}, y_i});
        zi = '0;
      end else begin
        xi = x_q[s-1];
        yi = y_q[s-1];
        zi = z_q[s-1];
      end
      if (yi >= 0) begin
        x_d[s] = xi + (yi >>> s);
        y_d[s] = yi - (xi >>> s);
        z_d[s] = zi + atan_q30(s);
      end else begin
        x_d[s] = xi - (yi >>> s);
        y_d[s] = yi + (xi >>> s);
        z_d[s] = zi - atan_q30(s);
      end
    end
  end

  always_comb begin
    v_d[0] = valid_i;
    for (int s = 1; s < STAGES; s++) begin
      v_d[s] = v_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
      tag_q[0] <= tag_i;
      for (int s = 1; s < STAGES; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];
  assign theta_o = z_q[STAGES-1];

endmodule

// ===== rtl/haversine_distance_midpoint_top.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: top level
// Great-circle distance in millimetres and mean position of two points.
// ----------------------------------------------------------------------------
// Usage:
// A point pair (two latitudes and longitudes in 1e-7 degree) is offered on
// pt_i; one result with distance_mm, mid_lat and mid_lon leaves on res_o.
// The sphere radius in metres is written on cfg_i, which is always ready;
// write it only while no pair is in flight.
// From input transfer to result a pair passes input reduction, radian
// scaling, the rotation CORDIC, three product stages, the 31-stage square
// root, the vectoring CORDIC and two scaling stages.
// Throughput is one pair per cycle while no result is held at the output;
// every stage is a register stage with its own valid bit.
// Reset empties the pipeline and sets the radius to 6371000 m.
// When the receiver holds off, the result stays on res_o and the whole
// pipeline freezes; pt_i.ready drops only while a result waits to be taken.
// ----------------------------------------------------------------------------
module haversine_distance_midpoint_top import hdm_pkg::*; #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdm_in_if.sink      pt_i,
  hdm_out_if.source   res_o,
  hdm_cfg_if.sink     cfg_i
);

  logic             adv;
  logic [RAD_W-1:0] radius_q;

  // Stage A: reduced angle magnitudes.
  logic signed [ANG_W-1:0] dlat, dlon, rlat, rlon, ap_a, ap_b, q_a, q_b;
  logic                    flip_a, flip_b;
  logic signed [LAT_W:0]   sum_lat;
  logic signed [LON_W:0]   sum_lon;
  logic [MAG_W-1:0]        a_mag_d [ROT_LANES];
  logic [MAG_W-1:0]        a_mag_q [ROT_LANES];
  logic [ROT_LANES-1:0]    a_neg_d, a_neg_q;
  rot_tag_t                a_tag_d, a_tag_q;
  logic                    a_v_q;

  // Stage B: Q30 radians.
  logic signed [ANG_W-1:0] b_z_d [ROT_LANES];
  logic signed [ANG_W-1:0] b_z_q [ROT_LANES];
  rot_tag_t                b_tag_q;
  logic                    b_v_q;

  logic                    sc_v;
  rot_tag_t                sc_tag;
  logic signed [ANG_W-1:0] sc_cos [ROT_LANES];
  logic signed [ANG_W-1:0] sc_sin [ROT_LANES];

  logic signed [ANG_W-1:0] c1, c2;
  logic signed [ANG_W-1:0] h1_p11_q, h1_p22_q, h1_pc_q;
  mid_t                    h1_mid_q;
  logic                    h1_v_q;
  logic signed [ANG_W-1:0] h2_p11_q, h2_t_q;
  mid_t                    h2_mid_q;
  logic                    h2_v_q;
  logic signed [ANG_W:0]   hsum;
  logic [HAV_W-1:0]        hav;
  logic [HAV_W-1:0]        h3_val_q [SQ_LANES];
  mid_t                    h3_mid_q;
  logic                    h3_v_q;

  logic                    sq_v;
  mid_t                    sq_mid;
  logic [HAV_W-1:0]        sq_root [SQ_LANES];

  logic                    vc_v;
  mid_t                    vc_mid;
  logic signed [ANG_W-1:0] vc_theta;

  logic [TH_W-1:0]         theta;
  logic [PROD_W-1:0]       d1_prod_q;
  mid_t                    d1_mid_q;
  logic                    d1_v_q;

  logic [PROD_W-31:0]      hi;
  logic [39:0]             lo_rnd;
  logic [DIST_W+1:0]       mm;
  logic                    res_valid_q;
  logic [DIST_W-1:0]       res_dist_q;
  mid_t                    res_mid_q;

  // The whole pipeline advances together unless a result is held at the output.
  assign adv        = !res_valid_q || res_o.ready;
  assign pt_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.data;
    end
  end

  // Stage A ------------------------------------------------------------------
  always_comb begin
    dlat = ANG_W'(pt_i.lat_b) - ANG_W'(pt_i.lat_a);
    dlon = ANG_W'(pt_i.lon_b) - ANG_W'(pt_i.lon_a);
    rlat = reduce_turn(dlat);
    rlon = reduce_turn(dlon);
    a_mag_d[LANE_S1] = (rlat < 0) ? MAG_W'(-rlat) : MAG_W'(rlat);
    a_mag_d[LANE_S2] = (rlon < 0) ? MAG_W'(-rlon) : MAG_W'(rlon);
    a_neg_d[LANE_S1] = rlat < 0;
    a_neg_d[LANE_S2] = rlon < 0;

    // Latitudes beyond a quarter turn use the supplementary angle, negated later.
    ap_a   = (pt_i.lat_a < 0) ? -ANG_W'(pt_i.lat_a) : ANG_W'(pt_i.lat_a);
    ap_b   = (pt_i.lat_b < 0) ? -ANG_W'(pt_i.lat_b) : ANG_W'(pt_i.lat_b);
    flip_a = ap_a > QUARTER_TURN;
    flip_b = ap_b > QUARTER_TURN;
    q_a    = flip_a ? HALF_TURN - ap_a : ap_a;
    q_b    = flip_b ? HALF_TURN - ap_b : ap_b;
    a_mag_d[LANE_C1] = MAG_W'(q_a <<< 1);
    a_mag_d[LANE_C2] = MAG_W'(q_b <<< 1);
    a_neg_d[LANE_C1] = 1'b0;
    a_neg_d[LANE_C2] = 1'b0;

    sum_lat = (LAT_W+1)'(pt_i.lat_a) + (LAT_W+1)'(pt_i.lat_b);
    sum_lon = (LON_W+1)'(pt_i.lon_a) + (LON_W+1)'(pt_i.lon_b);
    a_tag_d.flip    = {flip_b, flip_a};
    a_tag_d.mid.lat = sum_lat[LAT_W:1];
    a_tag_d.mid.lon = sum_lon[LON_W:1];
  end

  // Stage B ------------------------------------------------------------------
  always_comb begin
    logic [63:0]      rp;
    logic [MAG_W-1:0] r;
    for (int l = 0; l < ROT_LANES; l++) begin
      rp = {33'd0, a_mag_q[l]} * {32'd0, RAD_MUL} + 64'h8000_0000;
      r  = rp[MAG_W+31:32];
      b_z_d[l] = a_neg_q[l] ? -$signed({{(ANG_W-MAG_W){1'b0}}, r})
                            :  $signed({{(ANG_W-MAG_W){1'b0}}, r});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
      h3_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      a_v_q  <= pt_i.valid;
      b_v_q  <= a_v_q;
      h1_v_q <= sc_v;
      h2_v_q <= h1_v_q;
      h3_v_q <= h2_v_q;
      d1_v_q <= vc_v;
      res_valid_q <= d1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mag_q <= a_mag_d;
      a_neg_q <= a_neg_d;
      a_tag_q <= a_tag_d;
      b_z_q   <= b_z_d;
      b_tag_q <= a_tag_q;
    end
  end

  hdm_sincos #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  ($bits(rot_tag_t))
  ) u_hdm_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_v_q),
    .tag_i   (b_tag_q),
    .z_i     (b_z_q),
    .valid_o (sc_v),
    .tag_o   (sc_tag),
    .cos_o   (sc_cos),
    .sin_o   (sc_sin)
  );

  // Haversine term -----------------------------------------------------------
  assign c1 = sc_tag.flip[0] ? -sc_cos[LANE_C1] : sc_cos[LANE_C1];
  assign c2 = sc_tag.flip[1] ? -sc_cos[LANE_C2] : sc_cos[LANE_C2];

  always_comb begin
    hsum = (ANG_W+1)'(h2_p11_q) + (ANG_W+1)'(h2_t_q);
    if (hsum < 0) begin
      hav = '0;
    end else if (hsum > $signed({{(ANG_W+1-HAV_W){1'b0}}, HAV_ONE})) begin
      hav = HAV_ONE;
    end else begin
      hav = hsum[HAV_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_p11_q    <= mulq(sc_sin[LANE_S1], sc_sin[LANE_S1]);
      h1_p22_q    <= mulq(sc_sin[LANE_S2], sc_sin[LANE_S2]);
      h1_pc_q     <= mulq(c1, c2);
      h1_mid_q    <= sc_tag.mid;
      h2_p11_q    <= h1_p11_q;
      h2_t_q      <= mulq(h1_pc_q, h1_p22_q);
      h2_mid_q    <= h1_mid_q;
      h3_val_q[0] <= hav;
      h3_val_q[1] <= HAV_ONE - hav;
      h3_mid_q    <= h2_mid_q;
    end
  end

  hdm_isqrt #(
    .TAG_W ($bits(mid_t))
  ) u_hdm_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (h3_v_q),
    .tag_i   (h3_mid_q),
    .val_i   (h3_val_q),
    .valid_o (sq_v),
    .tag_o   (sq_mid),
    .root_o  (sq_root)
  );

  hdm_vector #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  ($bits(mid_t))
  ) u_hdm_vector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .tag_i   (sq_mid),
    .x_i     (sq_root[1]),
    .y_i     (sq_root[0]),
    .valid_o (vc_v),
    .tag_o   (vc_mid),
    .theta_o (vc_theta)
  );

  // Distance scaling ---------------------------------------------------------
  always_comb begin
    if (vc_theta < 0) begin
      theta = '0;
    end else if (vc_theta > $signed({{(ANG_W-TH_W){1'b0}}, THETA_MAX})) begin
      theta = THETA_MAX;
    end else begin
      theta = vc_theta[TH_W-1:0];
    end
  end

  // Whole metres times 1000, plus the rounded fractional part in millimetres.
  always_comb begin
    hi     = d1_prod_q[PROD_W-1:30];
    lo_rnd = 40'(d1_prod_q[29:0]) * 40'd1000 + 40'h00_2000_0000;
    mm     = (DIST_W+2)'(hi) * (DIST_W+2)'(1000) + (DIST_W+2)'(lo_rnd[39:30]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_prod_q  <= PROD_W'(radius_q) * PROD_W'({theta, 1'b0});
      d1_mid_q   <= vc_mid;
      res_dist_q <= (mm > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : mm[DIST_W-1:0];
      res_mid_q  <= d1_mid_q;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.distance_mm = res_dist_q;
  assign res_o.mid_lat     = res_mid_q.lat;
  assign res_o.mid_lon     = res_mid_q.lon;

endmodule

// ===== rtl/hdm_checker.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: port checker
// Watches the top-level channels for flow-control slips.
// ----------------------------------------------------------------------------
module hdm_checker import hdm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [DIST_W-1:0]       dist_i,
  input logic signed [LAT_W-1:0] mid_lat_i,
  input logic signed [LON_W-1:0] mid_lon_i,
  input logic                    cfg_ready_i
);

  // A result that is not taken stays in place with its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dist_i) &&
                                    $stable(mid_lat_i) && $stable(mid_lon_i))
    else $error("result changed while stalled");

  // The input side is only held off by a result waiting at the output.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without an output stall");

  // The input side is free in every cycle in which a result transfer happens.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> in_ready_i)
    else $error("input not ready during an output transfer");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("radius write channel not ready");

endmodule

bind haversine_distance_midpoint_top hdm_checker u_hdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .dist_i      (res_o.distance_mm),
  .mid_lat_i   (res_o.mid_lat),
  .mid_lon_i   (res_o.mid_lon),
  .cfg_ready_i (cfg_i.ready)
);

// ===== verif/haversine_distance_midpoint_top_tb.sv =====
// ----------------------------------------------------------------------------
// Haversine distance and midpoint: block-level testbench
// Drives point pairs through the pipelined distance block under several
// sphere radii. It predicts each distance and mean position in bit-exact
// fixed point and checks every result transfer in order. Both sides idle at
// random, and one long output stall backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module haversine_distance_midpoint_top_tb;
  import hdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STAGES     = 32;
  localparam int     LATENCY    = 2 * STAGES + 38;
  localparam int     WDOG_LIMIT = 4000;
  localparam longint ONE_Q30    = 64'sd1 << 30;
  localparam longint TURN       = 64'sd3600000000;
  localparam longint HALF       = 64'sd1800000000;
  localparam longint QUARTER    = 64'sd900000000;

  typedef struct {
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
  } pair_t;

  typedef struct {
    logic [DIST_W-1:0]       dist_mm;
    logic signed [LAT_W-1:0] mlat;
    logic signed [LON_W-1:0] mlon;
  } fix_t;

  logic clk_i;
  logic rst_ni;

  hdm_in_if  pt_if ();
  hdm_out_if res_if ();
  hdm_cfg_if cfg_if ();

  haversine_distance_midpoint_top #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  pair_t       pending_pairs[$];
  fix_t        expected_fixes[$];
  longint      atan_tab[STAGES];
  logic [23:0] radius_m;
  int          errors;
  bit          send_gaps;
  bit          recv_gaps;
  int          hold_request;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic void build_atan_table();
    longint unsigned sum, term;
    int unsigned     sh;
    for (int i = 0; i < STAGES; i++) begin
      sum = 0;
      if (i == 0) begin
        sum = 64'hC90FDAA22168C235 >> 2;
      end else begin
        for (int k = 0; ; k++) begin
          sh = i * (2 * k + 1);
          if (sh > 62) break;
          term = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else            sum = sum + term;
        end
      end
      atan_tab[i] = longint'((sum + (64'd1 << 31)) >> 32);
    end
  endfunction

  function automatic longint wrap_turn(longint d);
    longint r;
    r = d % TURN;
    if (r > HALF)  r = r - TURN;
    if (r < -HALF) r = r + TURN;
    return r;
  endfunction

  function automatic longint half_units_rad(longint v);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = (m * longint'(RAD_MUL) + (64'd1 << 31)) >> 32;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  // Rotation mode from (gain, 0): returns cosine and sine of z.
  function automatic void rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint half_sine(longint diff);
    longint c, s;
    rotate(half_units_rad(wrap_turn(diff)), c, s);
    return s;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint p, ap, q, c, s;
    bit     flip;
    p    = wrap_turn(lat);
    ap   = (p < 0) ? -p : p;
    flip = ap > QUARTER;
    q    = flip ? HALF - ap : ap;
    rotate(half_units_rad(2 * q), c, s);
    return flip ? -c : c;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic fix_t predict_fix(pair_t p, logic [23:0] rad);
    fix_t            f;
    longint          la, lo_a, lb, lo_b, s1, s2, c1, c2, hav, theta, msum;
    longint unsigned rx, ry, prod, hi, lo, mm;
    la   = p.lat_a;
    lo_a = p.lon_a;
    lb   = p.lat_b;
    lo_b = p.lon_b;
    s1 = half_sine(lb - la);
    s2 = half_sine(lo_b - lo_a);
    c1 = lat_cosine(la);
    c2 = lat_cosine(lb);
    hav = qmul(s1, s1) + qmul(qmul(c1, c2), qmul(s2, s2));
    if (hav < 0)       hav = 0;
    if (hav > ONE_Q30) hav = ONE_Q30;
    ry = floor_sqrt(longint'(hav) << 30);
    rx = floor_sqrt(longint'(ONE_Q30 - hav) << 30);
    theta = vector_angle(longint'(rx), longint'(ry));
    if (theta < 0)                  theta = 0;
    if (theta > longint'(THETA_MAX)) theta = THETA_MAX;
    prod = longint'(rad) * longint'(2 * theta);
    hi   = prod >> 30;
    lo   = prod & ((64'd1 << 30) - 1);
    mm   = hi * 1000 + ((lo * 1000 + (64'd1 << 29)) >> 30);
    if (mm > longint'(DIST_MAX)) mm = DIST_MAX;
    f.dist_mm = mm[DIST_W-1:0];
    msum   = (la + lb) >>> 1;
    f.mlat = msum[LAT_W-1:0];
    msum   = (lo_a + lo_b) >>> 1;
    f.mlon = msum[LON_W-1:0];
    return f;
  endfunction

  // ---------------- input driver ----------------

  int send_wait;

  always @(posedge clk_i) begin
    pair_t nxt;
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
      send_wait   <= 0;
    end else if (!pt_if.valid || pt_if.ready) begin
      if (pt_if.valid) begin
        nxt.lat_a = pt_if.lat_a;
        nxt.lon_a = pt_if.lon_a;
        nxt.lat_b = pt_if.lat_b;
        nxt.lon_b = pt_if.lon_b;
        expected_fixes.push_back(predict_fix(nxt, radius_m));
      end
      if (send_wait > 0) begin
        send_wait   <= send_wait - 1;
        pt_if.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        nxt = pending_pairs.pop_front();
        pt_if.lat_a <= nxt.lat_a;
        pt_if.lon_a <= nxt.lon_a;
        pt_if.lat_b <= nxt.lat_b;
        pt_if.lon_b <= nxt.lon_b;
        pt_if.valid <= 1'b1;
        send_wait   <= send_gaps ? $urandom_range(0, 7) : 0;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------

  int recv_wait;
  int hold_left;

  always @(posedge clk_i) begin
    fix_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait    <= 0;
      hold_left    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_fixes.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_fixes.pop_front();
          if (res_if.distance_mm !== want.dist_mm) begin
            $error("distance_mm: expected %0d, got %0d", want.dist_mm, res_if.distance_mm);
            errors++;
          end
          if (res_if.mid_lat !== want.mlat) begin
            $error("mid_lat: expected %0d, got %0d", want.mlat, res_if.mid_lat);
            errors++;
          end
          if (res_if.mid_lon !== want.mlon) begin
            $error("mid_lon: expected %0d, got %0d", want.mlon, res_if.mid_lon);
            errors++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    <= hold_request;
        hold_request = 0;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait    <= recv_wait - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (res_if.valid && res_if.ready && recv_gaps) recv_wait <= $urandom_range(0, 7);
      end
    end
  end

  // ---------------- watchdog ----------------

  int quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)
        || (pending_pairs.size() == 0 && expected_fixes.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------

  function automatic pair_t make_pair(longint la, longint loa, longint lb, longint lob);
    pair_t p;
    p.lat_a = la[LAT_W-1:0];
    p.lon_a = loa[LON_W-1:0];
    p.lat_b = lb[LAT_W-1:0];
    p.lon_b = lob[LON_W-1:0];
    return p;
  endfunction

  function automatic longint any_lat();
    return longint'($urandom_range(0, 1800000000)) - QUARTER;
  endfunction

  function automatic longint any_lon();
    return longint'($urandom_range(0, 3600000000)) - HALF;
  endfunction

  function automatic pair_t random_pair();
    longint la, loa;
    int     pick;
    pick = $urandom_range(0, 99);
    la   = any_lat();
    loa  = any_lon();
    if (pick < 65) begin
      return make_pair(la, loa, any_lat(), any_lon());
    end else if (pick < 80) begin
      // Raw bit patterns, out-of-range coordinates included.
      return make_pair($urandom(), $urandom(), $urandom(), $urandom());
    end else if (pick < 90) begin
      // Nearby points: short distances.
      return make_pair(la, loa, la + $urandom_range(0, 2000) - 1000,
                       loa + $urandom_range(0, 2000) - 1000);
    end else begin
      // Nearly antipodal points.
      return make_pair(la, loa, -la + $urandom_range(0, 200) - 100,
                       loa + HALF + $urandom_range(0, 200) - 100);
    end
  endfunction

  task automatic write_radius(logic [23:0] value);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    radius_m = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    @(posedge clk_i);
    while (pending_pairs.size() > 0 || pt_if.valid || expected_fixes.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
  endtask

  logic [23:0] radius_plan[5] = '{24'd1, 24'd10000000, 24'd0, 24'hFFFFFF, 24'd6371000};

  initial begin
    errors       = 0;
    hold_request = 0;
    send_gaps    = 1'b0;
    recv_gaps    = 1'b0;
    radius_m     = RADIUS_RESET;
    rst_ni       = 1'b0;
    pt_if.valid  = 1'b0;
    pt_if.lat_a  = '0;
    pt_if.lon_a  = '0;
    pt_if.lat_b  = '0;
    pt_if.lon_b  = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    build_atan_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs at the reset radius, back to back.
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(QUARTER, 0, -QUARTER, 0));
    pending_pairs.push_back(make_pair(QUARTER, 1234, QUARTER, -1234567));
    pending_pairs.push_back(make_pair(0, -HALF, 0, HALF));
    pending_pairs.push_back(make_pair(0, 0, 0, HALF));
    pending_pairs.push_back(make_pair(-QUARTER, -HALF, QUARTER, HALF));
    pending_pairs.push_back(make_pair(123456789, 0, 123456789, 1));
    pending_pairs.push_back(make_pair(1, 1, 0, 0));
    pending_pairs.push_back(make_pair(-1, -1, 0, 0));
    pending_pairs.push_back(make_pair(-3, 5, 0, -2));
    pending_pairs.push_back(make_pair(450000000, 900000000, -450000000, -900000000));
    pending_pairs.push_back(make_pair(-(64'sd1 << 30), -(64'sd1 << 31),
                                      (64'sd1 << 30) - 1, (64'sd1 << 31) - 1));
    pending_pairs.push_back(make_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1,
                                      -(64'sd1 << 30), -(64'sd1 << 31)));
    pending_pairs.push_back(make_pair(-(64'sd1 << 30), -(64'sd1 << 31),
                                      -(64'sd1 << 30), -(64'sd1 << 31)));
    pending_pairs.push_back(make_pair(1000000000, 0, -1000000000, 0));
    pending_pairs.push_back(make_pair(515000000, -1200000, 408000000, 740000000));
    pending_pairs.push_back(make_pair(-338000000, 1512000000, 406000000, -740000000));
    pending_pairs.push_back(make_pair(QUARTER, HALF, QUARTER - 1, -HALF));
    drain_pipeline();

    // Random phases, one per radius; gaps and stalls vary per phase.
    foreach (radius_plan[i]) begin
      write_radius(radius_plan[i]);
      send_gaps = (i % 2 == 0);
      recv_gaps = (i % 3 != 1);
      queue_random(150);
      if (i == 3) begin
        // Long output hold while input keeps coming, to fill the pipeline.
        send_gaps    = 1'b0;
        hold_request = 400;
      end
      queue_random(180);
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
